>>> sv/etx_pkg.sv
// Package for the escaped frame transmitter: byte codes, sequencer steps,
// queue entry types and the CRC-32 / hex helpers.
// No dependencies.
`default_nettype none

package etx_pkg;

  // Special byte values
  localparam logic [7:0] ESC_BYTE   = 8'h5C;
  localparam logic [7:0] TILDE_BYTE = 8'h7E;
  localparam logic [7:0] NL_BYTE    = 8'h0A;
  localparam logic [7:0] SPACE_BYTE = 8'h20;
  localparam logic [7:0] ESC_FLIP   = 8'h20;

  // Reflected CRC-32
  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  // Output sequencer steps for one queued item
  localparam logic [3:0] STEP_ESC     = 4'd0;   // escape prefix
  localparam logic [3:0] STEP_BYTE    = 4'd1;   // the data byte itself
  localparam logic [3:0] STEP_SPACE   = 4'd2;   // trailer separator
  localparam logic [3:0] STEP_HEX_TOP = 4'd10;  // last hex digit step
  localparam logic [3:0] STEP_NL      = 4'd11;  // closing newline

  // Classified item handed from front to back
  typedef struct packed {
    logic [7:0]  data;
    logic        esc;
    logic        last;
    logic [31:0] crc;   // final (inverted) CRC, meaningful when last
  } desc_t;

  // Queue write side
  typedef struct packed {
    logic  push;
    desc_t desc;
  } q_wr_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic  valid;
    desc_t desc;
  } q_rd_t;

  // One byte of reflected CRC-32, bitwise
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'h0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Upper-case ASCII hex digit
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) begin
      r = 8'h30 + {4'h0, nib};
    end else begin
      r = 8'h41 + {4'h0, nib - 4'd10};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> sv/etx_in_if.sv
// Input channel interface: raw frame bytes with last-byte flag.
// Depends on nothing.
`default_nettype none

interface etx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_last;

  modport source (output valid, output data_byte, output frame_last, input ready);
  modport sink   (input valid, input data_byte, input frame_last, output ready);
endinterface

`default_nettype wire

>>> sv/etx_out_if.sv
// Output channel interface: encoded serial bytes with run and frame markers.
// Depends on nothing.
`default_nettype none

interface etx_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       frame_end;

  modport source (output valid, output out_byte, output run_last, output frame_end,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input frame_end,
                  output ready);
endinterface

`default_nettype wire

>>> sv/etx_front.sv
// Front end: accepts raw bytes, runs the CRC and classifies each item.
// Depends on etx_pkg and etx_in_if.
`default_nettype none

module etx_front (
  input  wire            clk,
  input  wire            rst_n,
  etx_in_if.sink         in_ch,
  input  wire            q_full,
  output etx_pkg::q_wr_t q_wr
);

  logic [31:0] crc_r;
  logic [31:0] crc_nxt;
  logic [31:0] crc_upd;
  logic        accept;
  logic [7:0]  b;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign b           = in_ch.data_byte;

  // CRC over the unescaped byte; restart after the frame's last byte
  always_comb begin
    crc_upd = etx_pkg::crc_byte(crc_r, b);
    crc_nxt = crc_r;
    if (accept) begin
      crc_nxt = in_ch.frame_last ? etx_pkg::CRC_INIT : crc_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= etx_pkg::CRC_INIT;
    end else begin
      crc_r <= crc_nxt;
    end
  end

  // Classification into a queue entry
  always_comb begin
    q_wr.push      = accept;
    q_wr.desc.data = b;
    q_wr.desc.esc  = (b == etx_pkg::TILDE_BYTE) || (b == etx_pkg::NL_BYTE) ||
                     (b == etx_pkg::ESC_BYTE);
    q_wr.desc.last = in_ch.frame_last;
    q_wr.desc.crc  = crc_upd ^ etx_pkg::CRC_INIT;
  end

endmodule

`default_nettype wire

>>> sv/etx_queue.sv
// Small FIFO of classified items between front and back ends.
// Depends on etx_pkg.
`default_nettype none

module etx_queue #(
  parameter int DEPTH = 4
) (
  input  wire            clk,
  input  wire            rst_n,
  input  etx_pkg::q_wr_t q_wr,
  input  wire            pop,
  output logic           full,
  output etx_pkg::q_rd_t q_rd
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  etx_pkg::desc_t mem_r [DEPTH];
  logic [PW-1:0]  wptr_r, wptr_nxt;
  logic [PW-1:0]  rptr_r, rptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           do_push, do_pop;

  assign full       = (count_r == CW'(DEPTH));
  assign q_rd.valid = (count_r != '0);
  assign q_rd.desc  = mem_r[rptr_r];
  assign do_push    = q_wr.push && !full;
  assign do_pop     = pop && q_rd.valid;

  // Pointer and count update
  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= q_wr.desc;
    end
  end

endmodule

`default_nettype wire

>>> sv/etx_back.sv
// Back end: steps through the output bytes of the queue head item into a
// registered output stage. Depends on etx_pkg and etx_out_if.
`default_nettype none

module etx_back (
  input  wire            clk,
  input  wire            rst_n,
  input  etx_pkg::q_rd_t q_rd,
  output logic           pop,
  etx_out_if.source      out_ch
);

  logic [3:0] step_r, step_nxt;
  logic [3:0] eff;
  logic       fin;
  logic       load;
  logic [2:0] nib_idx;
  logic [7:0] byte_val;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r;
  logic       run_last_r;
  logic       frame_end_r;

  // Skip the escape prefix for plain bytes
  assign eff     = (step_r == etx_pkg::STEP_ESC && !q_rd.desc.esc) ? etx_pkg::STEP_BYTE
                                                                   : step_r;
  assign fin     = q_rd.desc.last ? (eff == etx_pkg::STEP_NL) : (eff == etx_pkg::STEP_BYTE);
  assign load    = q_rd.valid && (!out_valid_r || out_ch.ready);
  assign pop     = load && fin;
  assign nib_idx = 3'(etx_pkg::STEP_HEX_TOP - eff);

  // Byte for the current step
  always_comb begin
    case (eff)
      etx_pkg::STEP_ESC:   byte_val = etx_pkg::ESC_BYTE;
      etx_pkg::STEP_BYTE:  byte_val = q_rd.desc.data ^
                                      (q_rd.desc.esc ? etx_pkg::ESC_FLIP : 8'h00);
      etx_pkg::STEP_SPACE: byte_val = etx_pkg::SPACE_BYTE;
      etx_pkg::STEP_NL:    byte_val = etx_pkg::NL_BYTE;
      default:             byte_val = etx_pkg::hex_char(q_rd.desc.crc[{nib_idx, 2'b00} +: 4]);
    endcase
  end

  // Sequencer and output valid
  always_comb begin
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      step_nxt      = fin ? etx_pkg::STEP_ESC : eff + 4'd1;
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= etx_pkg::STEP_ESC;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r  <= byte_val;
      run_last_r  <= fin;
      frame_end_r <= (eff == etx_pkg::STEP_NL);
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_byte  = out_byte_r;
  assign out_ch.run_last  = run_last_r;
  assign out_ch.frame_end = frame_end_r;

endmodule

`default_nettype wire

>>> sv/escaped_frame_tx_crc32_top.sv
// Escaped frame transmitter with CRC-32 trailer, top level.
// An item's first output byte is valid after the queue and the output register.
// Throughput: one output byte per cycle while out_ch.ready; an item is one byte (plain),
// two (escaped), plus ten for the trailer; input is taken each cycle the queue has room.
// Reset: synchronous active-low rst_n empties the queue and output stage and sets the
// CRC to all ones.
`default_nettype none

module escaped_frame_tx_crc32_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire       clk,
  input  wire       rst_n,
  etx_in_if.sink    in_ch,
  etx_out_if.source out_ch
);

  etx_pkg::q_wr_t q_wr;
  etx_pkg::q_rd_t q_rd;
  logic           q_full;
  logic           q_pop;

  etx_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_wr   (q_wr)
  );

  etx_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .q_wr  (q_wr),
    .pop   (q_pop),
    .full  (q_full),
    .q_rd  (q_rd)
  );

  etx_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_rd   (q_rd),
    .pop    (q_pop),
    .out_ch (out_ch)
  );

`ifndef SYNTH
  // Front never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_wr.push |-> !q_full)
    else $error("push into full queue");

  // Back only retires an item that is present
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_rd.valid)
    else $error("pop from empty queue");

  // Frame end is the newline closing the item's run
  a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.frame_end) |->
      (out_ch.run_last && out_ch.out_byte == etx_pkg::NL_BYTE))
    else $error("frame end not on closing newline");

  // A retired item leaves an output byte on the next cycle
  a_pop_emits: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (out_ch.valid && out_ch.run_last))
    else $error("retired item without run-last byte");
`endif

endmodule

`default_nettype wire

>>> tb/tb_escaped_frame_tx_crc32_top.sv
`timescale 1ns / 1ps
// Testbench for escaped_frame_tx_crc32_top: drives raw frame bytes and checks the
// escaped byte stream and CRC-32 trailer against an in-bench predictor.
// Depends on etx_pkg, etx_in_if, etx_out_if and the top-level RTL.

module tb_escaped_frame_tx_crc32_top;

  localparam int HOLD_CYCLES  = 200;   // long receiver hold-off
  localparam int DRAIN_CYCLES = 20;    // settle time after the last output item
  localparam int RANDOM_ITEMS = 340;

  // Receiver stall patterns
  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_COIN,
    RX_PERIODIC,
    RX_SPARSE
  } rx_mode_t;

  // One expected encoded byte
  typedef struct packed {
    logic [7:0] code;
    logic       run_last;
    logic       frame_end;
  } enc_byte_t;

  logic clk = 1'b0;
  logic rst_n;

  etx_in_if  in_ch ();
  etx_out_if out_ch ();

  escaped_frame_tx_crc32_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  enc_byte_t   encoded_q[$];
  logic [31:0] frame_crc = etx_pkg::CRC_INIT;
  int          errors    = 0;
  int          burst_left = 0;
  logic        hold_rx   = 1'b0;
  rx_mode_t    rx_mode   = RX_ALWAYS;
  int unsigned rx_cycle  = 0;

  // Clock: 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Reflected CRC-32, one data bit folded in per shift
  function automatic logic [31:0] crc_advance(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (etx_pkg::CRC_POLY & {32{c[0] ^ b[i]}});
    end
    return c;
  endfunction

  function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
    logic [7:0] ch;
    if (nib > 4'd9) begin
      ch = "A" - 8'd10 + {4'h0, nib};
    end else begin
      ch = "0" + {4'h0, nib};
    end
    return ch;
  endfunction

  // Work out the encoded bytes one raw byte causes and queue them
  task automatic predict_encoding(input logic [7:0] b, input logic lst);
    enc_byte_t   run[$];
    logic [31:0] sum;
    frame_crc = crc_advance(frame_crc, b);
    if (b == etx_pkg::TILDE_BYTE || b == etx_pkg::NL_BYTE || b == etx_pkg::ESC_BYTE) begin
      run.push_back('{etx_pkg::ESC_BYTE, 1'b0, 1'b0});
      run.push_back('{b ^ etx_pkg::ESC_FLIP, 1'b0, 1'b0});
    end else begin
      run.push_back('{b, 1'b0, 1'b0});
    end
    if (lst) begin
      sum = frame_crc ^ etx_pkg::CRC_INIT;
      run.push_back('{etx_pkg::SPACE_BYTE, 1'b0, 1'b0});
      for (int k = 7; k >= 0; k--) begin
        run.push_back('{hex_ascii(sum[k*4 +: 4]), 1'b0, 1'b0});
      end
      run.push_back('{etx_pkg::NL_BYTE, 1'b0, 1'b1});
      frame_crc = etx_pkg::CRC_INIT;
    end
    run[run.size()-1].run_last = 1'b1;
    foreach (run[i]) encoded_q.push_back(run[i]);
  endtask

  // Offer one item in bursts with random gaps; returns once it is accepted
  task automatic send_byte(input logic [7:0] b, input logic lst);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_ch.valid      <= 1'b1;
    in_ch.data_byte  <= b;
    in_ch.frame_last <= lst;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_encoding(b, lst);
  endtask

  // Random byte weighted toward the escaped values and the extremes
  function automatic logic [7:0] pick_byte();
    int sel;
    logic [7:0] b;
    sel = $urandom_range(0, 99);
    if (sel < 8) begin
      b = etx_pkg::TILDE_BYTE;
    end else if (sel < 15) begin
      b = etx_pkg::NL_BYTE;
    end else if (sel < 22) begin
      b = etx_pkg::ESC_BYTE;
    end else if (sel < 26) begin
      b = 8'h00;
    end else if (sel < 30) begin
      b = 8'hFF;
    end else if (sel < 33) begin
      b = etx_pkg::SPACE_BYTE;
    end else begin
      b = 8'($urandom_range(0, 255));
    end
    return b;
  endfunction

  // Special bytes, extremes, and one-byte frames (first item closes a frame)
  task automatic test_special_bytes();
    send_byte(etx_pkg::TILDE_BYTE, 1'b1);
    send_byte(etx_pkg::TILDE_BYTE, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(etx_pkg::NL_BYTE, 1'b0);
    send_byte(etx_pkg::ESC_BYTE, 1'b0);
    send_byte(etx_pkg::SPACE_BYTE, 1'b0);
    send_byte(8'h7D, 1'b0);
    send_byte(etx_pkg::NL_BYTE, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(etx_pkg::ESC_BYTE, 1'b1);
  endtask

  // Standard check string; the trailer must read CBF43926
  task automatic test_check_string();
    string s;
    s = "123456789";
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i], i == s.len() - 1);
    end
  endtask

  // Receiver holds off while the sender keeps offering, filling the queue
  task automatic test_input_stall();
    hold_rx <= 1'b1;
    for (int i = 0; i < 40; i++) begin
      send_byte(i == 0 ? etx_pkg::TILDE_BYTE : pick_byte(), i == 39);
    end
  endtask

  // Random frames: mostly well-formed headers, some arbitrary first bytes
  task automatic test_random_frames();
    int sent;
    int flen;
    logic [7:0] b;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      flen = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 12);
      for (int i = 0; i < flen; i++) begin
        if (i == 0 && $urandom_range(0, 99) < 85) begin
          b = etx_pkg::TILDE_BYTE;
        end else begin
          b = pick_byte();
        end
        send_byte(b, i == flen - 1);
      end
      sent += flen;
    end
  endtask

  // Receiver ready: switches stall pattern now and then, long hold on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rx_cycle++;
      if (hold_rx) begin
        out_ch.ready <= 1'b0;
        hold_rx      <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (rx_cycle % 128 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
        case (rx_mode)
          RX_ALWAYS:   out_ch.ready <= 1'b1;
          RX_COIN:     out_ch.ready <= 1'($urandom_range(0, 1));
          RX_PERIODIC: out_ch.ready <= (rx_cycle % 8) < 5;
          default:     out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Compare each output item with the oldest expectation
  always @(posedge clk) begin
    enc_byte_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (encoded_q.size() == 0) begin
        $error("unexpected output item: out_byte %02h", out_ch.out_byte);
        errors++;
      end else begin
        want = encoded_q.pop_front();
        if (out_ch.out_byte !== want.code) begin
          $error("out_byte: expected %02h, got %02h", want.code, out_ch.out_byte);
          errors++;
        end
        if (out_ch.run_last !== want.run_last) begin
          $error("run_last: expected %0b, got %0b", want.run_last, out_ch.run_last);
          errors++;
        end
        if (out_ch.frame_end !== want.frame_end) begin
          $error("frame_end: expected %0b, got %0b", want.frame_end, out_ch.frame_end);
          errors++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("[escaped_frame_tx_crc32_top] ERROR");
    $finish;
  end

  // Test sequence
  initial begin
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.data_byte  <= 8'h00;
    in_ch.frame_last <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_special_bytes();
    test_check_string();
    test_input_stall();
    test_random_frames();

    in_ch.valid <= 1'b0;
    while (encoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("[escaped_frame_tx_crc32_top] OK");
    end else begin
      $display("[escaped_frame_tx_crc32_top] ERROR");
    end
    $finish;
  end

endmodule
